@@ hw/rtl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer package
// Types, codes and reset constants shared by the lamp controller files.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int PIN_W    = 4;
    localparam int TICK_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int CODE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0]  HOLD_TICKS_RESET     = TICK_W'(2 * 10 * 60);
    localparam logic [COUNT_W-1:0] DEBOUNCE_LIMIT_RESET = COUNT_W'(10);
    localparam logic [PIN_W-1:0]   PIN_INVERT_RESET     = PIN_W'(10);

    localparam logic [CODE_W-1:0] TIMED_CODE = 8'b1010_0001;
    localparam logic [CODE_W-1:0] REQ_TIMED  = 8'b1110_0001;
    localparam logic [CODE_W-1:0] REQ_ON     = 8'b1100_0001;
    localparam logic [CODE_W-1:0] REQ_OFF    = 8'b1100_0000;
    localparam logic [CODE_W-1:0] BUSY_BITS  = 8'b1100_0000;
    localparam int HOLD_BIT = 6;
    localparam int ADD_BIT  = 5;

    localparam logic [PIN_W-1:0] TIMED_BUTTONS  = 4'b1001;
    localparam logic [PIN_W-1:0] TOGGLE_BUTTONS = 4'b0110;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TICKS     = 2'd0,
        REG_DEBOUNCE_LIMIT = 2'd1,
        REG_PIN_INVERT     = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] debounce_limit;
        logic [PIN_W-1:0]   pin_invert_mask;
    } cfg_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [PIN_W-1:0]   pin_levels;
    } item_t;

    typedef struct packed {
        logic               lamp_lit;
        logic               indicator_led;
        logic               timed_mode;
        logic [TICK_W-1:0]  remaining_ticks;
    } result_t;

endpackage

@@ hw/rtl/slt_if.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer channels
// Valid/ready channel interfaces for sample items and result items.
// ----------------------------------------------------------------------------
interface slt_in_if;
    import slt_pkg::*;

    logic             valid;
    logic             ready;
    opcode_t          opcode;
    logic [PIN_W-1:0] pin_levels;

    modport source (output valid, output opcode, output pin_levels, input ready);
    modport sink   (input valid, input opcode, input pin_levels, output ready);
endinterface

interface slt_out_if;
    import slt_pkg::*;

    logic              valid;
    logic              ready;
    logic              lamp_lit;
    logic              indicator_led;
    logic              timed_mode;
    logic [TICK_W-1:0] remaining_ticks;

    modport source (output valid, output lamp_lit, output indicator_led,
                    output timed_mode, output remaining_ticks, input ready);
    modport sink   (input valid, input lamp_lit, input indicator_led,
                    input timed_mode, input remaining_ticks, output ready);
endinterface

@@ hw/rtl/slt_cfg.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer configuration registers
// Write-only register file for hold time, debounce limit and pin polarity.
// ----------------------------------------------------------------------------
module slt_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0] cfg_data,
    output slt_pkg::cfg_t                  cfg
);
    import slt_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks      <= HOLD_TICKS_RESET;
            cfg_reg.debounce_limit  <= DEBOUNCE_LIMIT_RESET;
            cfg_reg.pin_invert_mask <= PIN_INVERT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_TICKS:     cfg_reg.hold_ticks      <= cfg_data[TICK_W-1:0];
                REG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit  <= cfg_data[COUNT_W-1:0];
                REG_PIN_INVERT:     cfg_reg.pin_invert_mask <= cfg_data[PIN_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/slt_core.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer core
// Debounce, request commit and countdown state with its one-item update.
// ----------------------------------------------------------------------------
module slt_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  slt_pkg::cfg_t   cfg,
    input  logic            step,
    input  slt_pkg::item_t  item,
    output slt_pkg::result_t result_next
);
    import slt_pkg::*;

    logic [PIN_W-1:0]   last_pattern_reg, last_pattern_next;
    logic [COUNT_W-1:0] press_count_reg, press_count_next;
    logic [COUNT_W-1:0] release_count_reg, release_count_next;
    logic [CODE_W-1:0]  pending_reg, pending_next;
    logic [CODE_W-1:0]  lamp_mode_reg, lamp_mode_next;
    logic [TICK_W-1:0]  countdown_reg, countdown_next;
    logic               flash_reg, flash_next;

    always_comb
    begin
        logic [PIN_W-1:0]   pat;
        logic [COUNT_W-1:0] pc_inc;
        logic [CODE_W-1:0]  committed;
        logic [TICK_W:0]    sum;
        logic [TICK_W-1:0]  cd_dec;

        last_pattern_next  = last_pattern_reg;
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        pending_next       = pending_reg;
        lamp_mode_next     = lamp_mode_reg;
        countdown_next     = countdown_reg;
        flash_next         = flash_reg;

        pat       = item.pin_levels ^ cfg.pin_invert_mask;
        pc_inc    = (press_count_reg == COUNT_MAX) ? COUNT_MAX : press_count_reg + 1'b1;
        committed = pending_reg;
        committed[HOLD_BIT] = 1'b0;
        sum       = {1'b0, countdown_reg} + {1'b0, cfg.hold_ticks};
        cd_dec    = countdown_reg - 1'b1;

        case (item.opcode)
            OP_SAMPLE:
            begin
                if (pat != '0)
                begin
                    if ((pending_reg & BUSY_BITS) == '0)
                    begin
                        if (pat == last_pattern_reg)
                        begin
                            press_count_next = pc_inc;
                            if (pc_inc > cfg.debounce_limit)
                            begin
                                if ((pat & TIMED_BUTTONS) != '0)
                                begin
                                    pending_next = REQ_TIMED;
                                end
                                else if ((pat & TOGGLE_BUTTONS) != '0)
                                begin
                                    pending_next   = (lamp_mode_reg != '0) ? REQ_OFF : REQ_ON;
                                    countdown_next = '0;
                                end
                            end
                        end
                        else
                        begin
                            last_pattern_next  = pat;
                            press_count_next   = '0;
                            release_count_next = '0;
                        end
                    end
                    else
                    begin
                        release_count_next = '0;
                    end
                end
                else
                begin
                    press_count_next = '0;
                    if (pending_reg[HOLD_BIT])
                    begin
                        if (release_count_reg > cfg.debounce_limit)
                        begin
                            if (committed[ADD_BIT])
                            begin
                                countdown_next = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
                            end
                            lamp_mode_next = committed;
                            pending_next   = '0;
                        end
                        release_count_next = (release_count_reg == COUNT_MAX) ?
                                             COUNT_MAX : release_count_reg + 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (!lamp_mode_reg[0])
                begin
                    lamp_mode_next = '0;
                    flash_next     = 1'b0;
                end
                if (countdown_reg != '0 && lamp_mode_reg == TIMED_CODE)
                begin
                    flash_next     = !flash_reg;
                    countdown_next = cd_dec;
                    if (cd_dec == '0)
                    begin
                        lamp_mode_next = '0;
                    end
                end
                else
                begin
                    countdown_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pattern_reg  <= '0;
            press_count_reg   <= '0;
            release_count_reg <= '0;
            pending_reg       <= '0;
            lamp_mode_reg     <= '0;
            countdown_reg     <= '0;
            flash_reg         <= 1'b0;
        end
        else if (step)
        begin
            last_pattern_reg  <= last_pattern_next;
            press_count_reg   <= press_count_next;
            release_count_reg <= release_count_next;
            pending_reg       <= pending_next;
            lamp_mode_reg     <= lamp_mode_next;
            countdown_reg     <= countdown_next;
            flash_reg         <= flash_next;
        end
    end

    assign result_next.lamp_lit        = lamp_mode_next[0];
    assign result_next.indicator_led   = flash_next;
    assign result_next.timed_mode      = (lamp_mode_next == TIMED_CODE);
    assign result_next.remaining_ticks = countdown_next;

endmodule

@@ hw/rtl/staircase_lamp_timer_controller.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer controller
// Four-button debounced lamp control with timed and toggle modes.
// ----------------------------------------------------------------------------
// A result passes through the input register, then the result register, before it is offered.
// Throughput: one item per cycle while results are taken; the core state updates once per item.
// An empty input register takes one more item while a result waits; then the input stalls.
// Reset: asynchronous, active low; clears valid flags and core state, loads register defaults.
module staircase_lamp_timer_controller
(
    input  logic                           clk,
    input  logic                           rst_n,
    slt_in_if.sink                         sample,
    slt_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slt_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;

    slt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slt_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (advance),
        .item        (item_reg),
        .result_next (res_next)
    );

    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                item_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_reg.opcode     <= sample.opcode;
            item_reg.pin_levels <= sample.pin_levels;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.lamp_lit        = res_reg.lamp_lit;
    assign result.indicator_led   = res_reg.indicator_led;
    assign result.timed_mode      = res_reg.timed_mode;
    assign result.remaining_ticks = res_reg.remaining_ticks;

endmodule

@@ sim/slt_lamp_checker.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer checker
// Watches the sample, result and register write ports of the lamp controller.
// It keeps its own copy of the controller state to work out the lamp status
// that each sample transfer should produce. It then compares every result
// transfer, field by field, with the oldest status still awaited.
// ----------------------------------------------------------------------------
module slt_lamp_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    slt_in_if                              sample,
    slt_out_if                             result,
    input  logic                           cfg_we,
    input  logic [slt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             awaited_count
);
    import slt_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [TICK_W-1:0]  hold_cfg;
    logic [COUNT_W-1:0] limit_cfg;
    logic [PIN_W-1:0]   mask_cfg;

    logic [PIN_W-1:0]   last_pat;
    logic [COUNT_W-1:0] press_cnt;
    logic [COUNT_W-1:0] release_cnt;
    logic [CODE_W-1:0]  request;
    logic [CODE_W-1:0]  lamp_mode;
    logic [TICK_W-1:0]  countdown;
    logic               flash;

    result_t awaited_status[$];
    int      failures = 0;
    int      outstanding = 0;

    assign mismatch_count = failures;
    assign awaited_count  = outstanding;

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("[%0t] lamp status error: %s", $realtime, msg);
        end
    endtask

    function automatic result_t advance_lamp(input opcode_t op,
                                             input logic [PIN_W-1:0] pins);
        logic [PIN_W-1:0] pat;
        logic [TICK_W:0]  sum;
        result_t          status;
        pat = pins ^ mask_cfg;
        if (op == OP_SAMPLE)
        begin
            if (pat != '0)
            begin
                if ((request & BUSY_BITS) == '0 && pat == last_pat)
                begin
                    press_cnt = (press_cnt == COUNT_MAX) ? COUNT_MAX : press_cnt + 1'b1;
                    if (press_cnt > limit_cfg)
                    begin
                        if ((pat & TIMED_BUTTONS) != '0)
                        begin
                            request = REQ_TIMED;
                        end
                        else if ((pat & TOGGLE_BUTTONS) != '0)
                        begin
                            request   = (lamp_mode != '0) ? REQ_OFF : REQ_ON;
                            countdown = '0;
                        end
                    end
                end
                else
                begin
                    if ((request & BUSY_BITS) == '0)
                    begin
                        last_pat  = pat;
                        press_cnt = '0;
                    end
                    release_cnt = '0;
                end
            end
            else
            begin
                press_cnt = '0;
                if (request[HOLD_BIT])
                begin
                    if (release_cnt > limit_cfg)
                    begin
                        request[HOLD_BIT] = 1'b0;
                        if (request[ADD_BIT])
                        begin
                            sum       = countdown + hold_cfg;
                            countdown = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
                        end
                        lamp_mode = request;
                        request   = '0;
                    end
                    release_cnt = (release_cnt == COUNT_MAX) ? COUNT_MAX : release_cnt + 1'b1;
                end
            end
        end
        else
        begin
            if (!lamp_mode[0])
            begin
                lamp_mode = '0;
                flash     = 1'b0;
            end
            if (countdown != '0 && lamp_mode == TIMED_CODE)
            begin
                flash     = ~flash;
                countdown = countdown - 1'b1;
                if (countdown == '0)
                begin
                    lamp_mode = '0;
                end
            end
            else
            begin
                countdown = '0;
            end
        end
        status.lamp_lit        = lamp_mode[0];
        status.indicator_led   = flash;
        status.timed_mode      = (lamp_mode == TIMED_CODE);
        status.remaining_ticks = countdown;
        return status;
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            hold_cfg    = HOLD_TICKS_RESET;
            limit_cfg   = DEBOUNCE_LIMIT_RESET;
            mask_cfg    = PIN_INVERT_RESET;
            last_pat    = '0;
            press_cnt   = '0;
            release_cnt = '0;
            request     = '0;
            lamp_mode   = '0;
            countdown   = '0;
            flash       = 1'b0;
            awaited_status.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_TICKS:     hold_cfg  = cfg_data[TICK_W-1:0];
                    REG_DEBOUNCE_LIMIT: limit_cfg = cfg_data[COUNT_W-1:0];
                    REG_PIN_INVERT:     mask_cfg  = cfg_data[PIN_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got.lamp_lit        = result.lamp_lit;
                got.indicator_led   = result.indicator_led;
                got.timed_mode      = result.timed_mode;
                got.remaining_ticks = result.remaining_ticks;
                if (awaited_status.size() == 0)
                begin
                    log_failure($sformatf({"result transfer with nothing awaited: ",
                                           "lamp=%b led=%b timed=%b ticks=%0d"},
                                          got.lamp_lit, got.indicator_led, got.timed_mode,
                                          got.remaining_ticks));
                end
                else
                begin
                    want = awaited_status.pop_front();
                    if (got.lamp_lit !== want.lamp_lit
                        || got.indicator_led !== want.indicator_led
                        || got.timed_mode !== want.timed_mode
                        || got.remaining_ticks !== want.remaining_ticks)
                    begin
                        log_failure($sformatf({"expected lamp=%b led=%b timed=%b ticks=%0d, ",
                                               "got lamp=%b led=%b timed=%b ticks=%0d"},
                                              want.lamp_lit, want.indicator_led, want.timed_mode,
                                              want.remaining_ticks, got.lamp_lit,
                                              got.indicator_led, got.timed_mode,
                                              got.remaining_ticks));
                    end
                end
            end
            if (sample.valid && sample.ready)
            begin
                awaited_status.push_back(advance_lamp(sample.opcode, sample.pin_levels));
            end
        end
        outstanding <= awaited_status.size();
    end

endmodule

@@ sim/staircase_lamp_timer_controller_tb.sv @@
// ----------------------------------------------------------------------------
// Staircase lamp timer controller testbench
// Drives button samples and timer ticks into the lamp controller through
// several register settings and idling patterns. The checker beside the
// controller predicts every lamp status. A short directed opening is followed
// by random press and release sequences, ticks and noise, including a long
// hold that saturates the press counter.
// ----------------------------------------------------------------------------
module staircase_lamp_timer_controller_tb;
    import slt_pkg::*;

    localparam int                   IDLE_HEAVY      = 81;
    localparam int                   IDLE_LIGHT      = 12;
    localparam int                   HOLD_OFF_CYCLES = 40;
    localparam int                   DRAIN_CYCLES    = 4;
    localparam int                   WATCHDOG_LIMIT  = 4000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    awaited_count;

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    bit                    hold_off_req = 1'b0;
    int                    items_sent = 0;
    int                    idle_cycles = 0;
    logic [TICK_W-1:0]     cur_hold;
    logic [COUNT_W-1:0]    cur_limit;
    logic [PIN_W-1:0]      cur_mask;

    slt_in_if  sample_ch ();
    slt_out_if result_ch ();

    staircase_lamp_timer_controller DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slt_lamp_checker checker_inst
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample_ch),
        .result         (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            if (hold_off_req)
            begin
                repeat (HOLD_OFF_CYCLES)
                begin
                    result_ch.ready <= 1'b0;
                    @(posedge clk);
                end
                hold_off_req = 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic push_sample(input opcode_t op, input logic [PIN_W-1:0] pins);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.opcode     <= op;
        sample_ch.pin_levels <= pins;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [TICK_W-1:0] hold, input logic [COUNT_W-1:0] limit,
                                input logic [PIN_W-1:0] mask);
        cur_hold  = hold;
        cur_limit = limit;
        cur_mask  = mask;
        cfg_we    <= 1'b1;
        cfg_index <= REG_HOLD_TICKS;
        cfg_data  <= CFG_DATA_W'(hold);
        @(posedge clk);
        cfg_index <= REG_DEBOUNCE_LIMIT;
        cfg_data  <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_index <= REG_PIN_INVERT;
        cfg_data  <= CFG_DATA_W'(mask);
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic press_release(input logic [PIN_W-1:0] pat, input int reps, input int rels);
        repeat (reps + 1)
        begin
            if ($urandom_range(99) < 10)
            begin
                push_sample(OP_TICK, PIN_W'($urandom));
            end
            push_sample(OP_SAMPLE, pat ^ cur_mask);
        end
        repeat (rels)
        begin
            if ($urandom_range(99) < 10)
            begin
                push_sample(OP_TICK, PIN_W'($urandom));
            end
            push_sample(OP_SAMPLE, cur_mask);
        end
    endtask

    task automatic random_stream(input int n);
        int               target;
        int               roll;
        int               reps;
        int               rels;
        logic [PIN_W-1:0] pat;
        target = items_sent + n;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
            begin
                push_sample(opcode_t'($urandom_range(1)), PIN_W'($urandom));
            end
            else if (roll < 30)
            begin
                repeat ($urandom_range(6, 1)) push_sample(OP_TICK, PIN_W'($urandom));
            end
            else
            begin
                pat  = $urandom_range(1) ? PIN_W'(1 << $urandom_range(3))
                                         : PIN_W'($urandom_range(15, 1));
                reps = cur_limit + 1 + $urandom_range(2);
                rels = cur_limit + 2 + $urandom_range(2);
                if ($urandom_range(99) < 15)
                begin
                    reps = $urandom_range(cur_limit);
                end
                if ($urandom_range(99) < 15)
                begin
                    rels = $urandom_range(cur_limit);
                end
                press_release(pat, reps, rels);
            end
        end
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] hold, input logic [COUNT_W-1:0] limit,
                             input logic [PIN_W-1:0] mask, input int send_pct,
                             input int recv_pct, input int n);
        settle();
        write_config(hold, limit, mask);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        random_stream(n);
    endtask

    initial
    begin
        item_t opening [24];
        opening = '{
            '{OP_TICK, 4'h0}, '{OP_SAMPLE, 4'h0},
            '{OP_SAMPLE, 4'h1}, '{OP_SAMPLE, 4'h1}, '{OP_SAMPLE, 4'h1},
            '{OP_SAMPLE, 4'h0}, '{OP_SAMPLE, 4'h1}, '{OP_SAMPLE, 4'h0}, '{OP_SAMPLE, 4'h0},
            '{OP_SAMPLE, 4'h8}, '{OP_SAMPLE, 4'h8}, '{OP_SAMPLE, 4'h0}, '{OP_SAMPLE, 4'h0},
            '{OP_TICK, 4'h0}, '{OP_TICK, 4'h0},
            '{OP_SAMPLE, 4'h2}, '{OP_SAMPLE, 4'h2}, '{OP_SAMPLE, 4'h0}, '{OP_SAMPLE, 4'h0},
            '{OP_SAMPLE, 4'h4}, '{OP_SAMPLE, 4'h4}, '{OP_SAMPLE, 4'h0}, '{OP_SAMPLE, 4'h0},
            '{OP_TICK, 4'hF}
        };
        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.opcode     <= OP_SAMPLE;
        sample_ch.pin_levels <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_HOLD_TICKS;
        cfg_data             <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A press, a held press with a release in between, a saturating
        // second timed press, blinking, and a toggle off repeated before a tick.
        write_config(TICK_MAX, 8'd0, 4'h0);
        foreach (opening[i])
        begin
            push_sample(opening[i].opcode, opening[i].pin_levels);
        end

        run_phase(16'd3, 8'd1, PIN_W'($urandom), 0, 0, 50);
        run_phase(16'd1, 8'd0, PIN_W'($urandom), IDLE_HEAVY, 0, 50);
        run_phase(TICK_W'($urandom_range(8, 1)), 8'd2, PIN_W'($urandom), 0, IDLE_HEAVY, 50);

        settle();
        write_config(TICK_MAX, 8'd3, PIN_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        random_stream(30);
        send_idle_pct  = IDLE_LIGHT;
        recv_stall_pct = IDLE_LIGHT;
        random_stream(50);

        // The press counter saturates while the request can never be made.
        run_phase(16'd5, COUNT_MAX, 4'hF, 0, 0, 0);
        press_release(4'h1, 258, 3);
        push_sample(OP_TICK, 4'h0);

        run_phase(HOLD_TICKS_RESET, DEBOUNCE_LIMIT_RESET, PIN_INVERT_RESET, 0, IDLE_HEAVY, 50);

        settle();
        if (mismatch_count == 0 && awaited_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
